[hw/rtl/crcacc_pkg.sv]
// Shared constants and the per-cell word type of the CRC-32C accumulate unit.
`timescale 1ns / 1ps

package crcacc_pkg;

  // Castagnoli polynomial 0x1EDC6F41, bit-reflected
  localparam logic [31:0] CRC_POLY_REFL = 32'h82F6_3B78;

  localparam int CRC_W   = 32;
  localparam int DATA_W  = 64;
  localparam int FUNC_W  = 2;
  localparam int BYTE_W  = 8;
  localparam int NUM_CELLS = DATA_W / BYTE_W;
  localparam int REM_W   = $clog2(NUM_CELLS + 1);

  // Operand size codes
  localparam logic [FUNC_W-1:0] SIZE_BYTE  = 2'd0;
  localparam logic [FUNC_W-1:0] SIZE_WORD  = 2'd1;
  localparam logic [FUNC_W-1:0] SIZE_DWORD = 2'd2;
  localparam logic [FUNC_W-1:0] SIZE_QWORD = 2'd3;

  // Word handed from cell to cell: running CRC, unfolded data, bytes left
  typedef struct packed {
    logic [CRC_W-1:0]  crc;
    logic [DATA_W-1:0] data;
    logic [REM_W-1:0]  rem;
  } cell_word_t;

  // Number of bytes folded for a size code
  function automatic logic [REM_W-1:0] size_bytes(input logic [FUNC_W-1:0] func);
    logic [REM_W-1:0] n;
    case (func)
      SIZE_BYTE:  n = REM_W'(1);
      SIZE_WORD:  n = REM_W'(2);
      SIZE_DWORD: n = REM_W'(4);
      SIZE_QWORD: n = REM_W'(8);
      default:    n = REM_W'(8);
    endcase
    return n;
  endfunction

endpackage

[hw/rtl/crcacc_cell.sv]
// One pipeline cell: folds the low data byte into the CRC while bytes remain and passes the word on.
`timescale 1ns / 1ps

module crcacc_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  crcacc_pkg::cell_word_t  up_word,
  output logic                    dn_valid,
  input  logic                    dn_ready,
  output crcacc_pkg::cell_word_t  dn_word
);

  logic                   valid_r;
  crcacc_pkg::cell_word_t word_r;
  crcacc_pkg::cell_word_t word_nxt;

  // Bit-serial reflected CRC over one byte, LSB first
  function automatic logic [crcacc_pkg::CRC_W-1:0] fold_byte(
    input logic [crcacc_pkg::CRC_W-1:0]  crc,
    input logic [crcacc_pkg::BYTE_W-1:0] b
  );
    logic [crcacc_pkg::CRC_W-1:0] c;
    logic                         fb;
    c = crc;
    for (int i = 0; i < crcacc_pkg::BYTE_W; i++) begin
      fb = c[0] ^ b[i];
      c  = (c >> 1) ^ (crcacc_pkg::CRC_POLY_REFL & {crcacc_pkg::CRC_W{fb}});
    end
    return c;
  endfunction

  // Fold only while bytes remain; data always moves down one byte
  always_comb begin
    word_nxt      = up_word;
    word_nxt.data = up_word.data >> crcacc_pkg::BYTE_W;
    if (up_word.rem != '0) begin
      word_nxt.crc = fold_byte(up_word.crc, up_word.data[crcacc_pkg::BYTE_W-1:0]);
      word_nxt.rem = up_word.rem - crcacc_pkg::REM_W'(1);
    end
  end

  // Cell takes a word when empty or when its own word leaves
  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      word_r <= word_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_word  = word_r;

endmodule

[hw/rtl/crc32c_accumulate_unit.sv]
// Top level of the CRC-32C accumulate unit: a row of byte-folding cells.
//
//   channel | dir | handshake            | payload
//   in_     | in  | in_tvalid/in_tready  | tdata: crc_in, data_in; tuser: func
//   out_    | out | out_tvalid/out_tready| tdata: crc_out
//
// Throughput is one word per cycle while the output is not stalled; each word
// passes through every cell of the eight-cell row, each cell folding one data byte while bytes remain.
// Each cell has its own valid flag, so empty cells close up behind a stalled
// output and input keeps flowing until every cell holds a word.
// rst_n (synchronous, active low) clears the valid flags only.
`timescale 1ns / 1ps

module crc32c_accumulate_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // [31:0] crc_in, [95:32] data_in
  input  logic [1:0]  in_tuser,   // [1:0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [31:0] crc_out
);

  localparam int N = crcacc_pkg::NUM_CELLS;

  logic                   valid_c [N+1];
  logic                   ready_c [N+1];
  crcacc_pkg::cell_word_t word_c  [N+1];
  logic [N-1:0]           busy;

  // Entry word into the first cell
  always_comb begin
    word_c[0].crc  = in_tdata[crcacc_pkg::CRC_W-1:0];
    word_c[0].data = in_tdata[crcacc_pkg::CRC_W +: crcacc_pkg::DATA_W];
    word_c[0].rem  = crcacc_pkg::size_bytes(in_tuser);
  end
  assign valid_c[0] = in_tvalid;
  assign in_tready  = ready_c[0];

  // Row of cells
  for (genvar k = 0; k < N; k++) begin : g_cell
    crcacc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (valid_c[k]),
      .up_ready (ready_c[k]),
      .up_word  (word_c[k]),
      .dn_valid (valid_c[k+1]),
      .dn_ready (ready_c[k+1]),
      .dn_word  (word_c[k+1])
    );
    assign busy[k] = valid_c[k+1];
  end

  // Last cell is the output register
  assign out_tvalid = valid_c[N];
  assign ready_c[N] = out_tready;
  assign out_tdata  = word_c[N].crc;

  // Every byte has been folded by the time a word leaves the row
  a_all_folded: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (word_c[N].rem == '0))
    else $error("word left the row with bytes unfolded");

  // Input stalls only with the row full and the output blocked
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> ((&busy) && !out_tready))
    else $error("input stalled with room in the row");

  // A word in the first cell moves on or stays; it never vanishes
  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    (busy[0] && !ready_c[1]) |=> busy[0])
    else $error("stalled word dropped from first cell");

endmodule

[dv/crc32c_accumulate_unit_checker.sv]
// Checker for the CRC-32C accumulate unit: predicts each output word and compares.
`timescale 1ns / 1ps

module crc32c_accumulate_unit_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [95:0] in_tdata,   // [31:0] crc_in, [95:32] data_in
  input  logic [1:0]  in_tuser,   // [1:0] func
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // [31:0] crc_out
  output int          fail_count,
  output int          pending_words
);

  // One accepted input word and the CRC it should produce
  typedef struct {
    logic [crcacc_pkg::CRC_W-1:0]  crc_in;
    logic [crcacc_pkg::DATA_W-1:0] data;
    logic [crcacc_pkg::FUNC_W-1:0] func;
    logic [crcacc_pkg::CRC_W-1:0]  crc_out;
  } crc_job_t;

  crc_job_t expected_crc[$];
  int       mismatches;

  // Bit-serial fold, LSB first, reflected Castagnoli polynomial
  function automatic logic [crcacc_pkg::CRC_W-1:0] fold_crc32c(
    input logic [crcacc_pkg::CRC_W-1:0]  crc,
    input logic [crcacc_pkg::DATA_W-1:0] data,
    input logic [crcacc_pkg::FUNC_W-1:0] func
  );
    int                           nbits;
    logic [crcacc_pkg::CRC_W-1:0] acc;
    logic                         fb;
    case (func)
      crcacc_pkg::SIZE_BYTE:  nbits = 8;
      crcacc_pkg::SIZE_WORD:  nbits = 16;
      crcacc_pkg::SIZE_DWORD: nbits = 32;
      default:                nbits = 64;
    endcase
    acc = crc;
    for (int i = 0; i < nbits; i++) begin
      fb  = acc[0] ^ data[i];
      acc = (acc >> 1) ^ (fb ? crcacc_pkg::CRC_POLY_REFL : '0);
    end
    return acc;
  endfunction

  always @(posedge clk) begin
    crc_job_t job;
    if (rst_n) begin
      // Record the expectation for each accepted input word
      if (in_tvalid && in_tready) begin
        job.crc_in  = in_tdata[31:0];
        job.data    = in_tdata[95:32];
        job.func    = in_tuser;
        job.crc_out = fold_crc32c(job.crc_in, job.data, job.func);
        expected_crc.push_back(job);
      end
      // Compare each accepted output word with the oldest expectation
      if (out_tvalid && out_tready) begin
        if (expected_crc.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected output word: crc_out=%h", out_tdata);
        end else begin
          job = expected_crc.pop_front();
          if (out_tdata !== job.crc_out) begin
            mismatches++;
            if (mismatches <= 10)
              $display("crc_out mismatch: crc_in=%h data=%h func=%0d expected %h got %h",
                       job.crc_in, job.data, job.func, job.crc_out, out_tdata);
          end
        end
      end
    end
    fail_count    <= mismatches;
    pending_words <= expected_crc.size();
  end

endmodule

[dv/crc32c_accumulate_unit_tb.sv]
// Testbench top for the CRC-32C accumulate unit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module crc32c_accumulate_unit_tb;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  int          fail_count;
  int          pending_words;

  int send_idle_pct;
  int recv_stall_pct;

  crc32c_accumulate_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  crc32c_accumulate_unit_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .fail_count    (fail_count),
    .pending_words (pending_words)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Run limit, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Offer one word, with random idle cycles ahead of it, and wait for acceptance
  task automatic send_word(input logic [crcacc_pkg::CRC_W-1:0]  crc,
                           input logic [crcacc_pkg::DATA_W-1:0] data,
                           input logic [crcacc_pkg::FUNC_W-1:0] func);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {data, crc};
    in_tuser  <= func;
    do @(posedge clk); while (!in_tready);
  endtask

  // Random word, biased now and then toward all-zero and all-one values
  task automatic send_random_word();
    logic [crcacc_pkg::CRC_W-1:0]  crc;
    logic [crcacc_pkg::DATA_W-1:0] data;
    logic [crcacc_pkg::FUNC_W-1:0] func;
    crc  = $urandom;
    data = {$urandom, $urandom};
    func = crcacc_pkg::FUNC_W'($urandom_range(3));
    case ($urandom_range(19))
      0: crc  = '0;
      1: crc  = '1;
      2: data = '0;
      3: data = '1;
      default: ;
    endcase
    send_word(crc, data, func);
  endtask

  initial begin
    logic [crcacc_pkg::FUNC_W-1:0] sizes[4];
    int                            nbits;
    sizes = '{crcacc_pkg::SIZE_BYTE, crcacc_pkg::SIZE_WORD,
              crcacc_pkg::SIZE_DWORD, crcacc_pkg::SIZE_QWORD};
    rst_n          <= 1'b0;
    in_tvalid      <= 1'b0;
    in_tdata       <= '0;
    in_tuser       <= crcacc_pkg::SIZE_BYTE;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes per size, bits above the size, top bit of the size, a random data word
    foreach (sizes[s]) begin
      nbits = 8 << s;
      send_word('0, '0, sizes[s]);
      send_word('1, '1, sizes[s]);
      if (nbits < crcacc_pkg::DATA_W)
        send_word(32'h1234_5678, ~((64'd1 << nbits) - 1), sizes[s]);
      send_word(32'h8000_0001, 64'd1 << (nbits - 1), sizes[s]);
      send_word(32'hDEAD_BEEF, {$urandom, $urandom}, sizes[s]);
    end
    send_word(32'h0000_0001, 64'h8000_0000_0000_0001, crcacc_pkg::SIZE_QWORD);
    send_word('1, '0, crcacc_pkg::SIZE_QWORD);

    // Random phases: no idling, sender idle, receiver stalling, both
    repeat (240) send_random_word();
    send_idle_pct = 75;
    repeat (240) send_random_word();
    send_idle_pct  = 0;
    recv_stall_pct = 75;
    repeat (240) send_random_word();
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    repeat (240) send_random_word();

    // Drain
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
